// ----- rtl/core/skp_pkg.sv -----
package skp_pkg;

    localparam int MAX_Y_NNZ = 64;
    localparam int IDX_W     = $clog2(MAX_Y_NNZ);
    localparam int FILL_W    = $clog2(MAX_Y_NNZ + 1);

    localparam int ROW_W     = 16;
    localparam int VALUE_W   = 32;
    localparam int XRC_W     = 17;
    localparam int OUT_ROW_W = 32;
    localparam int PROD_W    = 64;
    localparam int COUNT_W   = 32;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_X    = 2'd1,
        CMD_END  = 2'd2
    } skp_cmd_t;

    typedef enum logic {
        KIND_PRODUCT = 1'b0,
        KIND_COUNT   = 1'b1
    } skp_kind_t;

    typedef struct packed {
        logic [1:0]                cmd;
        logic [ROW_W-1:0]          row;
        logic signed [VALUE_W-1:0] value;
    } skp_item_t;

    typedef struct packed {
        logic                     kind;
        logic [OUT_ROW_W-1:0]     out_row;
        logic signed [PROD_W-1:0] product;
        logic [COUNT_W-1:0]       entry_count;
        logic                     overflow;
        logic                     last;
    } skp_result_t;

    // one stored entry of the second matrix
    typedef struct packed {
        logic [ROW_W-1:0]          row;
        logic signed [VALUE_W-1:0] value;
    } skp_entry_t;

    // request from the sequencer to the result stage
    typedef struct packed {
        logic                      valid;
        logic                      is_end;
        logic                      last;
        logic                      overflow;
        logic [ROW_W-1:0]          x_row;
        logic signed [VALUE_W-1:0] x_value;
        logic [ROW_W-1:0]          y_row;
        logic signed [VALUE_W-1:0] y_value;
    } skp_req_t;

endpackage

// ----- rtl/core/sparse_column_kronecker_product_top.sv -----
// Column-wise Kronecker product of two sparse matrices, one column at a time.
// A load (cmd 0) and a column end (cmd 2) leave busy low; a column end gives
// its count result in the cycle after acceptance. A first-matrix entry (cmd 1)
// reads the stored second-matrix entries from the store memory, one per cycle,
// so with n entries stored it keeps busy high until its last read is done and gives n
// results on consecutive cycles through the store read and result registers; the
// single read port of the store sets that pace. Results are not held: each one
// shows on the result port for exactly one cycle with strobe high, and the
// receiver must take it then. x_row_count may be written whenever busy is low.
module sparse_column_kronecker_product_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  skp_pkg::skp_item_t               item,
    output logic                             strobe,
    output skp_pkg::skp_result_t             result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [skp_pkg::XRC_W-1:0]        cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                              state_reg;
    state_t                              state_next;
    logic [skp_pkg::IDX_W-1:0]           idx_reg;
    logic [skp_pkg::IDX_W-1:0]           idx_next;
    logic [skp_pkg::FILL_W-1:0]          fill_reg;
    logic [skp_pkg::FILL_W-1:0]          fill_next;
    logic                                ovf_reg;
    logic                                ovf_next;
    logic [skp_pkg::XRC_W-1:0]           xrc_reg;
    logic                                rd_valid_reg;
    logic                                rd_last_reg;
    logic [skp_pkg::ROW_W-1:0]           x_row_reg;
    logic signed [skp_pkg::VALUE_W-1:0]  x_value_reg;
    skp_pkg::skp_entry_t                 rd_data_reg;
    skp_pkg::skp_entry_t                 store [skp_pkg::MAX_Y_NNZ];

    logic                                accept;
    logic                                wr_en;
    logic                                take_x;
    logic                                take_end;
    logic                                rd_last;
    skp_pkg::skp_req_t                   req;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE) || rd_valid_reg;
    assign cfg_ready = 1'b1;
    assign rd_last   = ({1'b0, idx_reg} == (fill_reg - 1'b1));

    always_comb
    begin
        wr_en    = 1'b0;
        take_x   = 1'b0;
        take_end = 1'b0;
        fill_next = fill_reg;
        ovf_next  = ovf_reg;
        if (accept)
        begin
            unique case (item.cmd)
                skp_pkg::CMD_LOAD:
                begin
                    if (fill_reg < skp_pkg::FILL_W'(skp_pkg::MAX_Y_NNZ))
                    begin
                        wr_en     = 1'b1;
                        fill_next = fill_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                skp_pkg::CMD_X:
                begin
                    take_x = (fill_reg != '0);
                end
                skp_pkg::CMD_END:
                begin
                    take_end  = 1'b1;
                    fill_next = '0;
                    ovf_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_x)
                begin
                    state_next = ST_RUN;
                    idx_next   = '0;
                end
            end
            ST_RUN:
            begin
                idx_next = idx_reg + 1'b1;
                if (rd_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            xrc_reg      <= skp_pkg::XRC_W'(1);
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            fill_reg     <= fill_next;
            ovf_reg      <= ovf_next;
            rd_valid_reg <= (state_reg == ST_RUN);
            rd_last_reg  <= rd_last;
            if (cfg_valid && cfg_ready)
            begin
                xrc_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_x)
        begin
            x_row_reg   <= item.row;
            x_value_reg <= item.value;
        end
    end

    // store memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[fill_reg[skp_pkg::IDX_W-1:0]] <= '{row: item.row, value: item.value};
        end
        rd_data_reg <= store[idx_reg];
    end

    always_comb
    begin
        req.valid    = rd_valid_reg || take_end;
        req.is_end   = !rd_valid_reg;
        req.last     = rd_valid_reg ? rd_last_reg : 1'b1;
        req.overflow = ovf_reg;
        req.x_row    = x_row_reg;
        req.x_value  = x_value_reg;
        req.y_row    = rd_data_reg.row;
        req.y_value  = rd_data_reg.value;
    end

    skp_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .x_row_count (xrc_reg),
        .strobe      (strobe),
        .result      (result)
    );

endmodule

// ----- rtl/core/skp_emit.sv -----
module skp_emit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  skp_pkg::skp_req_t                req,
    input  logic [skp_pkg::XRC_W-1:0]        x_row_count,
    output logic                             strobe,
    output skp_pkg::skp_result_t             result
);

    logic [skp_pkg::COUNT_W-1:0]   count_reg;
    logic [skp_pkg::COUNT_W-1:0]   count_next;
    logic                          strobe_reg;
    skp_pkg::skp_result_t          result_reg;
    skp_pkg::skp_result_t          result_next;
    logic [skp_pkg::ROW_W+skp_pkg::XRC_W-1:0] row_scaled;
    logic signed [skp_pkg::PROD_W-1:0]         prod;

    assign row_scaled = {{skp_pkg::XRC_W{1'b0}}, req.y_row}
                      * {{skp_pkg::ROW_W{1'b0}}, x_row_count};
    assign prod       = skp_pkg::PROD_W'(req.x_value) * skp_pkg::PROD_W'(req.y_value);

    always_comb
    begin
        count_next  = count_reg;
        result_next = result_reg;
        if (req.valid)
        begin
            if (req.is_end)
            begin
                result_next.kind    = skp_pkg::KIND_COUNT;
                result_next.out_row = '0;
                result_next.product = '0;
            end
            else
            begin
                // running count saturates
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
                result_next.kind    = skp_pkg::KIND_PRODUCT;
                result_next.out_row = row_scaled[skp_pkg::OUT_ROW_W-1:0]
                                    + {{(skp_pkg::OUT_ROW_W-skp_pkg::ROW_W){1'b0}}, req.x_row};
                result_next.product = prod;
            end
            result_next.entry_count = count_next;
            result_next.overflow    = req.overflow;
            result_next.last        = req.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            strobe_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

// ----- rtl/core/skp_checks.sv -----
module skp_checks (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input skp_pkg::skp_item_t    item,
    input logic                  strobe,
    input skp_pkg::skp_result_t  result
);

    // a column end gives its count result in the next cycle
    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.cmd == skp_pkg::CMD_END)
        |=> strobe && (result.kind == skp_pkg::KIND_COUNT) && result.last)
        else $error("column end without count result");

    // a load transfer causes no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.cmd == skp_pkg::CMD_LOAD) |=> !strobe)
        else $error("result after a load");

    // products of one entry come on consecutive cycles
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == skp_pkg::KIND_PRODUCT) && !result.last
        |=> strobe && (result.kind == skp_pkg::KIND_PRODUCT))
        else $error("gap inside a product burst");

    // the count rises by one between products of one entry, or stays saturated
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == skp_pkg::KIND_PRODUCT) && !result.last
        |=> (result.entry_count == $past(result.entry_count) + 1'b1)
            || (result.entry_count == '1))
        else $error("product count out of step");

    // count results carry no row
    a_count_row: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (result.kind == skp_pkg::KIND_COUNT) |-> (result.out_row == '0))
        else $error("count result with a row");

endmodule

bind sparse_column_kronecker_product_top skp_checks u_skp_checks (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
);

// ----- tb/sparse_column_kronecker_product_top_test.sv -----
`timescale 1ns / 1ps

module sparse_column_kronecker_product_top_test;

    localparam logic [1:0] CMD_UNKNOWN    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 2000;
    localparam int         SETTLE_CYCLES  = 4;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    skp_pkg::skp_item_t            item = '0;
    logic                          strobe;
    skp_pkg::skp_result_t          result;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [skp_pkg::XRC_W-1:0]     cfg_data = '0;

    // software copy of the block state
    logic [skp_pkg::ROW_W-1:0]     y_row_mem [skp_pkg::MAX_Y_NNZ];
    logic [skp_pkg::VALUE_W-1:0]   y_value_mem [skp_pkg::MAX_Y_NNZ];
    int                            y_fill_cnt = 0;
    logic [skp_pkg::COUNT_W-1:0]   product_total = '0;
    logic                          dropped_load = 1'b0;
    logic [skp_pkg::XRC_W-1:0]     row_count_reg = 1;

    skp_pkg::skp_result_t          kron_out_q [$];
    int                            mismatch_count = 0;
    int                            idle_cycles = 0;
    bit                            no_idle = 1'b0;

    sparse_column_kronecker_product_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .strobe    (strobe),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic skp_pkg::skp_item_t make_item(
        input logic [1:0] cmd,
        input logic [skp_pkg::ROW_W-1:0] row,
        input logic [skp_pkg::VALUE_W-1:0] value);
        skp_pkg::skp_item_t it;
        it.cmd   = cmd;
        it.row   = row;
        it.value = value;
        return it;
    endfunction

    function automatic logic [skp_pkg::VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [skp_pkg::ROW_W-1:0] rand_row();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return skp_pkg::ROW_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // works out the results one accepted item gives and updates the copy of the state
    function automatic void apply_to_kronecker_model(input skp_pkg::skp_item_t it);
        skp_pkg::skp_result_t r;
        longint               xv;
        longint               yv;
        logic [63:0]          wide_row;
        case (it.cmd)
            skp_pkg::CMD_LOAD:
            begin
                if (y_fill_cnt < skp_pkg::MAX_Y_NNZ)
                begin
                    y_row_mem[y_fill_cnt]   = it.row;
                    y_value_mem[y_fill_cnt] = it.value;
                    y_fill_cnt++;
                end
                else
                    dropped_load = 1'b1;
            end
            skp_pkg::CMD_X:
            begin
                xv = it.value;
                for (int i = 0; i < y_fill_cnt; i++)
                begin
                    yv = signed'(y_value_mem[i]);
                    wide_row = 64'(it.row) + 64'(y_row_mem[i]) * 64'(row_count_reg);
                    if (product_total != COUNT_MAX)
                        product_total++;
                    r.kind        = skp_pkg::KIND_PRODUCT;
                    r.out_row     = wide_row[skp_pkg::OUT_ROW_W-1:0];
                    r.product     = xv * yv;
                    r.entry_count = product_total;
                    r.overflow    = dropped_load;
                    r.last        = (i == y_fill_cnt - 1);
                    kron_out_q.insert(kron_out_q.size(), r);
                end
            end
            skp_pkg::CMD_END:
            begin
                r.kind        = skp_pkg::KIND_COUNT;
                r.out_row     = '0;
                r.product     = '0;
                r.entry_count = product_total;
                r.overflow    = dropped_load;
                r.last        = 1'b1;
                kron_out_q.insert(kron_out_q.size(), r);
                y_fill_cnt   = 0;
                dropped_load = 1'b0;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    // start stays high into the next item when no gap follows
    task automatic send_item(input skp_pkg::skp_item_t it);
        int gap;
        item  <= it;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        apply_to_kronecker_model(it);
        gap = idle_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        while (kron_out_q.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_count(input logic [skp_pkg::XRC_W-1:0] count);
        drain();
        cfg_data  <= count;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        row_count_reg = count;
    endtask

    task automatic test_reset_state();
        send_item(make_item(skp_pkg::CMD_END, 16'd5, 32'h1234_5678));
        send_item(make_item(skp_pkg::CMD_X, 16'd9, 32'h0001_0000));
        send_item(make_item(CMD_UNKNOWN, 16'hFFFF, 32'hFFFF_FFFF));
        send_item(make_item(skp_pkg::CMD_LOAD, 16'd3, 32'h0002_0000));
        send_item(make_item(CMD_UNKNOWN, 16'd0, 32'h0));
        send_item(make_item(skp_pkg::CMD_X, 16'd1, 32'hFFFF_0000));
        send_item(make_item(skp_pkg::CMD_END, 16'd0, 32'h0));
    endtask

    task automatic test_field_extremes();
        send_item(make_item(skp_pkg::CMD_LOAD, 16'd0, 32'h7FFF_FFFF));
        send_item(make_item(skp_pkg::CMD_LOAD, 16'hFFFF, 32'h8000_0000));
        send_item(make_item(skp_pkg::CMD_LOAD, 16'd1, 32'hFFFF_FFFF));
        send_item(make_item(skp_pkg::CMD_LOAD, 16'h5555, 32'h0));
        send_item(make_item(skp_pkg::CMD_X, 16'hFFFF, 32'h8000_0000));
        send_item(make_item(skp_pkg::CMD_X, 16'd0, 32'h7FFF_FFFF));
        send_item(make_item(skp_pkg::CMD_X, 16'hAAAA, 32'h0001_0000));
        send_item(make_item(skp_pkg::CMD_END, 16'hFFFF, 32'hFFFF_FFFF));
    endtask

    // fill the store past capacity; the flag must last until the column end only
    task automatic test_store_full();
        for (int i = 0; i < skp_pkg::MAX_Y_NNZ + 3; i++)
            send_item(make_item(skp_pkg::CMD_LOAD, rand_row(), rand_value()));
        send_item(make_item(skp_pkg::CMD_X, rand_row(), rand_value()));
        send_item(make_item(skp_pkg::CMD_X, rand_row(), rand_value()));
        send_item(make_item(skp_pkg::CMD_END, 16'd0, 32'h0));
        send_item(make_item(skp_pkg::CMD_END, 16'd0, 32'h0));
    endtask

    task automatic test_row_count_settings();
        logic [skp_pkg::XRC_W-1:0] settings [4];
        settings = '{17'd0, 17'd65536, 17'h1FFFF, 17'd1};
        foreach (settings[s])
        begin
            write_row_count(settings[s]);
            send_item(make_item(skp_pkg::CMD_LOAD, 16'hFFFF, rand_value()));
            send_item(make_item(skp_pkg::CMD_LOAD, 16'd1, rand_value()));
            send_item(make_item(skp_pkg::CMD_X, 16'hFFFF, rand_value()));
            send_item(make_item(skp_pkg::CMD_END, 16'd0, 32'h0));
        end
    endtask

    // mostly well-formed columns with random content, some noise
    task automatic test_random_columns(input int n_items);
        int         sent;
        int         n_loads;
        int         n_x;
        logic [1:0] cmd;
        sent = 0;
        while (sent < n_items)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 8)
            begin
                n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 68)
                                                     : $urandom_range(0, 8);
                n_x = $urandom_range(1, 4);
                repeat (n_loads)
                    send_item(make_item(skp_pkg::CMD_LOAD, rand_row(), rand_value()));
                repeat (n_x)
                    send_item(make_item(skp_pkg::CMD_X, rand_row(), rand_value()));
                send_item(make_item(skp_pkg::CMD_END, rand_row(), rand_value()));
                sent += n_loads + n_x + 1;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    cmd = 2'($urandom_range(0, 3));
                    send_item(make_item(cmd, rand_row(), rand_value()));
                    if (cmd != CMD_UNKNOWN)
                        sent++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // each result is taken at the edge that ends its strobe cycle
    always @(posedge clk)
    begin
        skp_pkg::skp_result_t want;
        if (rst_n && strobe)
        begin
            if (kron_out_q.size() == 0)
                report_mismatch("result with nothing pending", 64'(result.out_row), '0);
            else
            begin
                want = kron_out_q.pop_front();
                if (result.kind !== want.kind)
                    report_mismatch("kind", 64'(result.kind), 64'(want.kind));
                if (result.out_row !== want.out_row)
                    report_mismatch("out_row", 64'(result.out_row), 64'(want.out_row));
                if (result.product !== want.product)
                    report_mismatch("product", result.product, want.product);
                if (result.entry_count !== want.entry_count)
                    report_mismatch("entry_count", 64'(result.entry_count),
                                    64'(want.entry_count));
                if (result.overflow !== want.overflow)
                    report_mismatch("overflow", 64'(result.overflow), 64'(want.overflow));
                if (result.last !== want.last)
                    report_mismatch("last", 64'(result.last), 64'(want.last));
            end
        end
    end

    // cycles with no transfer on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        write_row_count(17'd1);
        test_field_extremes();
        test_store_full();
        test_row_count_settings();
        for (int phase = 0; phase < 4; phase++)
        begin
            write_row_count((phase == 0) ? 17'd65536
                                         : skp_pkg::XRC_W'($urandom_range(0, 131071)));
            test_random_columns(25);
        end

        drain();
        if (mismatch_count == 0 && kron_out_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
